@@ rtl/vmap_pkg.sv @@
// ----------------------------------------------------------------------------
// vmap_pkg
// Shared types and constants for the video memory access port.
// ----------------------------------------------------------------------------
package vmap_pkg;

    localparam int VRAM_WORDS_DEF    = 32768;
    localparam int OAM_BYTES_DEF     = 544;
    localparam int PALETTE_BYTES_DEF = 512;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int LINE_W   = 9;
    localparam int DOT_W    = 11;
    localparam int OLATCH_W = 10;
    localparam int EFF_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [OP_W-1:0] OP_VRAM_RD = 3'd0;
    localparam logic [OP_W-1:0] OP_VRAM_WR = 3'd1;
    localparam logic [OP_W-1:0] OP_OAM_RD  = 3'd2;
    localparam logic [OP_W-1:0] OP_OAM_WR  = 3'd3;
    localparam logic [OP_W-1:0] OP_CG_RD   = 3'd4;
    localparam logic [OP_W-1:0] OP_CG_WR   = 3'd5;

    localparam logic [EFF_W-1:0] EFF_NONE = 2'd0;
    localparam logic [EFF_W-1:0] EFF_DATA = 2'd1;
    localparam logic [EFF_W-1:0] EFF_MDR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_DISABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_LINES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLACE_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL_REGION      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VRAM_REMAP_MODE = 3'd4;

    localparam logic [1:0] REMAP_NONE = 2'd0;
    localparam logic [1:0] REMAP_8    = 2'd1;
    localparam logic [1:0] REMAP_9    = 2'd2;
    localparam logic [1:0] REMAP_10   = 2'd3;

    localparam int NTSC_LINES = 525;
    localparam int PAL_LINES  = 625;
    localparam logic [LINE_W-1:0] LAST_LINE_NTSC = LINE_W'(NTSC_LINES / 2 - 1);
    localparam logic [LINE_W-1:0] LAST_LINE_PAL  = LINE_W'(PAL_LINES / 2 - 1);
    localparam logic [DOT_W-1:0]  LINE_END_DOT   = 11'd1362;
    localparam logic [DOT_W-1:0]  WR_EARLY_DOT   = 11'd4;
    localparam logic [DOT_W-1:0]  MDR_DOT        = 11'd6;

    localparam logic [OLATCH_W-1:0] OAM_HI_MASK = 10'h21f;
    localparam logic [DATA_W-1:0]   CG_ODD_MASK = 8'h7f;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic mem_en;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic        display_disable;
        logic [7:0]  visible_lines;
        logic        interlace_on;
        logic        pal_region;
        logic [1:0]  vram_remap_mode;
    } t_cfg;

endpackage

@@ rtl/vmap_ram.sv @@
// ----------------------------------------------------------------------------
// vmap_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/vmap_ctrl.sv @@
// ----------------------------------------------------------------------------
// vmap_ctrl
// Request sequencer: capture, memory access, result strobe.
// ----------------------------------------------------------------------------
module vmap_ctrl
    import vmap_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_busy       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                o_cmd.mem_en = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                o_cmd.done = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/vmap_datapath.sv @@
// ----------------------------------------------------------------------------
// vmap_datapath
// Config registers, address remap and folding, display gating, memories.
// ----------------------------------------------------------------------------
module vmap_datapath
    import vmap_pkg::*;
#(
    parameter int VRAM_WORDS    = VRAM_WORDS_DEF,
    parameter int OAM_BYTES     = OAM_BYTES_DEF,
    parameter int PALETTE_BYTES = PALETTE_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic                  i_byte_half,
    input  logic [DATA_W-1:0]     i_write_data,
    input  logic [LINE_W-1:0]     i_line_count,
    input  logic [DOT_W-1:0]      i_dot_count,
    input  logic                  i_odd_field,
    input  logic [DATA_W-1:0]     i_bus_mdr,
    input  logic [OLATCH_W-1:0]   i_oam_latched_address,
    output logic [DATA_W-1:0]     o_read_data,
    output logic [EFF_W-1:0]      o_write_effect
);

    localparam int VA_W = $clog2(VRAM_WORDS);
    localparam int OA_W = $clog2(OAM_BYTES);
    localparam int PA_W = $clog2(PALETTE_BYTES);

    function automatic logic [OLATCH_W-1:0] fold_oam(input logic [OLATCH_W-1:0] a);
        logic [OLATCH_W-1:0] f;
        f = a;
        if (a[9]) begin
            f = a & OAM_HI_MASK;
        end
        return f;
    endfunction

    t_cfg r_cfg;

    logic [OP_W-1:0]     r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_half;
    logic [DATA_W-1:0]   r_wdata;
    logic [LINE_W-1:0]   r_line;
    logic [DOT_W-1:0]    r_dot;
    logic                r_odd;
    logic [DATA_W-1:0]   r_mdr;
    logic [OLATCH_W-1:0] r_olatch;

    logic [ADDR_W-1:0]   w_remap;
    logic [VA_W-1:0]     w_vaddr;
    logic [OLATCH_W-1:0] w_oaddr_full;
    logic [PA_W-1:0]     w_paddr;
    logic                w_on;
    logic [LINE_W-1:0]   w_last;
    logic [LINE_W-1:0]   w_vd;
    logic [LINE_W-1:0]   w_vdm1;
    logic                w_vd_nz;
    logic                w_rd_ok;
    logic [EFF_W-1:0]    w_eff;
    logic [DATA_W-1:0]   w_vram_wbyte;
    logic [DATA_W-1:0]   w_cg_wbyte;
    logic                w_we_vlo;
    logic                w_we_vhi;
    logic                w_we_oam;
    logic                w_we_cg;
    logic [DATA_W-1:0]   w_vlo_rd;
    logic [DATA_W-1:0]   w_vhi_rd;
    logic [DATA_W-1:0]   w_oam_rd;
    logic [DATA_W-1:0]   w_cg_rd;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_disable <= 1'b1;
            r_cfg.visible_lines   <= 8'd225;
            r_cfg.interlace_on    <= 1'b0;
            r_cfg.pal_region      <= 1'b0;
            r_cfg.vram_remap_mode <= REMAP_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISPLAY_DISABLE: r_cfg.display_disable <= i_cfg_wdata[0];
                CFG_VISIBLE_LINES:   r_cfg.visible_lines   <= i_cfg_wdata;
                CFG_INTERLACE_ON:    r_cfg.interlace_on    <= i_cfg_wdata[0];
                CFG_PAL_REGION:      r_cfg.pal_region      <= i_cfg_wdata[0];
                CFG_VRAM_REMAP_MODE: r_cfg.vram_remap_mode <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_addr   <= i_address;
            r_half   <= i_byte_half;
            r_wdata  <= i_write_data;
            r_line   <= i_line_count;
            r_dot    <= i_dot_count;
            r_odd    <= i_odd_field;
            r_mdr    <= i_bus_mdr;
            r_olatch <= i_oam_latched_address;
        end
    end

    // vram address rotation
    always_comb begin
        case (r_cfg.vram_remap_mode)
            REMAP_8:  w_remap = {r_addr[15:8], r_addr[4:0], r_addr[7:5]};
            REMAP_9:  w_remap = {r_addr[15:9], r_addr[5:0], r_addr[8:6]};
            REMAP_10: w_remap = {r_addr[15:10], r_addr[6:0], r_addr[9:7]};
            default:  w_remap = r_addr;
        endcase
    end
    assign w_vaddr = w_remap[VA_W-1:0];

    // display window gating
    assign w_on    = !r_cfg.display_disable;
    assign w_vd    = {1'b0, r_cfg.visible_lines};
    assign w_vd_nz = (r_cfg.visible_lines != 8'd0);
    assign w_vdm1  = w_vd - 9'd1;
    assign w_last  = (r_cfg.pal_region ? LAST_LINE_PAL : LAST_LINE_NTSC)
                   + {8'd0, (r_cfg.interlace_on && !r_odd)};

    always_comb begin
        w_rd_ok = 1'b1;
        if (w_on) begin
            if (r_line == w_last && r_dot == LINE_END_DOT) begin
                w_rd_ok = 1'b0;
            end else if (w_vd_nz && r_line < w_vdm1) begin
                w_rd_ok = 1'b0;
            end else if (w_vd_nz && r_line == w_vdm1) begin
                w_rd_ok = (r_dot == LINE_END_DOT);
            end
        end
    end

    always_comb begin
        if (!w_on) begin
            w_eff = EFF_DATA;
        end else if (r_line == '0) begin
            if (r_dot <= WR_EARLY_DOT) begin
                w_eff = EFF_DATA;
            end else if (r_dot == MDR_DOT) begin
                w_eff = EFF_MDR;
            end else begin
                w_eff = EFF_NONE;
            end
        end else if (r_line < w_vd) begin
            w_eff = EFF_NONE;
        end else if (r_line == w_vd) begin
            w_eff = (r_dot > WR_EARLY_DOT) ? EFF_DATA : EFF_NONE;
        end else begin
            w_eff = EFF_DATA;
        end
    end

    // oam and palette addressing
    assign w_oaddr_full = (w_on && r_line < w_vd) ? fold_oam(r_olatch)
                                                  : fold_oam(r_addr[OLATCH_W-1:0]);
    assign w_paddr      = r_addr[PA_W-1:0];

    assign w_vram_wbyte = (w_eff == EFF_MDR) ? r_mdr : r_wdata;
    assign w_cg_wbyte   = w_paddr[0] ? (r_wdata & CG_ODD_MASK) : r_wdata;

    assign w_we_vlo = i_cmd.mem_en && r_op == OP_VRAM_WR && w_eff != EFF_NONE && !r_half;
    assign w_we_vhi = i_cmd.mem_en && r_op == OP_VRAM_WR && w_eff != EFF_NONE && r_half;
    assign w_we_oam = i_cmd.mem_en && r_op == OP_OAM_WR;
    assign w_we_cg  = i_cmd.mem_en && r_op == OP_CG_WR;

    vmap_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_WORDS)) u_vram_lo (
        .i_clk   (i_clk),
        .i_we    (w_we_vlo),
        .i_addr  (w_vaddr),
        .i_wdata (w_vram_wbyte),
        .o_rdata (w_vlo_rd)
    );

    vmap_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_WORDS)) u_vram_hi (
        .i_clk   (i_clk),
        .i_we    (w_we_vhi),
        .i_addr  (w_vaddr),
        .i_wdata (w_vram_wbyte),
        .o_rdata (w_vhi_rd)
    );

    vmap_ram #(.WIDTH(DATA_W), .DEPTH(OAM_BYTES)) u_oam (
        .i_clk   (i_clk),
        .i_we    (w_we_oam),
        .i_addr  (w_oaddr_full[OA_W-1:0]),
        .i_wdata (r_wdata),
        .o_rdata (w_oam_rd)
    );

    vmap_ram #(.WIDTH(DATA_W), .DEPTH(PALETTE_BYTES)) u_cgram (
        .i_clk   (i_clk),
        .i_we    (w_we_cg),
        .i_addr  (w_paddr),
        .i_wdata (w_cg_wbyte),
        .o_rdata (w_cg_rd)
    );

    // result select
    always_comb begin
        o_read_data    = '0;
        o_write_effect = EFF_NONE;
        unique case (r_op)
            OP_VRAM_RD: o_read_data = w_rd_ok ? (r_half ? w_vhi_rd : w_vlo_rd) : '0;
            OP_VRAM_WR: o_write_effect = w_eff;
            OP_OAM_RD:  o_read_data = w_oam_rd;
            OP_OAM_WR:  o_write_effect = EFF_DATA;
            OP_CG_RD:   o_read_data = w_paddr[0] ? (w_cg_rd & CG_ODD_MASK) : w_cg_rd;
            OP_CG_WR:   o_write_effect = EFF_DATA;
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/video_memory_access_port_core.sv @@
// ----------------------------------------------------------------------------
// video_memory_access_port_core
// CPU access port to vram, oam and cgram with remap and display gating.
//
//   channel   | handshake                | payload
//   ----------+--------------------------+---------------------------------
//   request   | start / busy             | i_opcode .. i_oam_latched_address
//   result    | o_result_valid (strobe)  | o_read_data, o_write_effect
//   config    | i_cfg_we                 | i_cfg_index, i_cfg_wdata
//
// each request runs through capture, single memory port access, result
// a new request is taken the cycle after the result strobe
// i_rst_n is synchronous; memories are not cleared and need software init
// the result is shown for one cycle only and cannot be held off
// ----------------------------------------------------------------------------
module video_memory_access_port_core
    import vmap_pkg::*;
#(
    parameter int VRAM_WORDS    = VRAM_WORDS_DEF,
    parameter int OAM_BYTES     = OAM_BYTES_DEF,
    parameter int PALETTE_BYTES = PALETTE_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic                  i_byte_half,
    input  logic [DATA_W-1:0]     i_write_data,
    input  logic [LINE_W-1:0]     i_line_count,
    input  logic [DOT_W-1:0]      i_dot_count,
    input  logic                  i_odd_field,
    input  logic [DATA_W-1:0]     i_bus_mdr,
    input  logic [OLATCH_W-1:0]   i_oam_latched_address,
    output logic                  o_result_valid,
    output logic [DATA_W-1:0]     o_read_data,
    output logic [EFF_W-1:0]      o_write_effect
);

    t_cmd w_cmd;

    vmap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    vmap_datapath #(
        .VRAM_WORDS    (VRAM_WORDS),
        .OAM_BYTES     (OAM_BYTES),
        .PALETTE_BYTES (PALETTE_BYTES)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_opcode              (i_opcode),
        .i_address             (i_address),
        .i_byte_half           (i_byte_half),
        .i_write_data          (i_write_data),
        .i_line_count          (i_line_count),
        .i_dot_count           (i_dot_count),
        .i_odd_field           (i_odd_field),
        .i_bus_mdr             (i_bus_mdr),
        .i_oam_latched_address (i_oam_latched_address),
        .o_read_data           (o_read_data),
        .o_write_effect        (o_write_effect)
    );

    assign o_result_valid = w_cmd.done;

`ifndef SYNTHESIS
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("result strobe missing after request");

    a_strobe_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_write_effect != EFF_NONE) |-> (o_read_data == '0))
        else $error("write request returned read data");

    a_effect_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_write_effect == EFF_NONE || o_write_effect == EFF_DATA
                            || o_write_effect == EFF_MDR))
        else $error("bad write effect code");
`endif

endmodule

@@ sim/video_memory_access_port_core_tb.sv @@
// ----------------------------------------------------------------------------
// video_memory_access_port_core_tb
// Self-checking bench for the video memory access port. A short table of
// edge cases runs first, then random traffic in phases with different
// display settings. Results of checked edge cases are compared with the table,
// all others with a predictor that keeps its own image of vram, oam and cgram.
// ----------------------------------------------------------------------------
module video_memory_access_port_core_tb
    import vmap_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int N_PHASES        = 8;
    localparam int N_DIRECTED      = 27;
    localparam int TAIL_CYCLES     = 6;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic                half;
        logic [DATA_W-1:0]   wdata;
        logic [LINE_W-1:0]   line;
        logic [DOT_W-1:0]    dot;
        logic                odd;
        logic [DATA_W-1:0]   mdr;
        logic [OLATCH_W-1:0] latched;
    } vm_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic [EFF_W-1:0]  eff;
    } vm_result_t;

    typedef struct packed {
        logic       blank;
        vm_req_t    req;
        logic       checked;
        vm_result_t result;
    } vm_row_t;

    // edge cases: forced blank first, then display on at 225 lines, ntsc
    localparam vm_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b1, '{OP_VRAM_WR, 16'h0000, 1'b0, 8'hff, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_VRAM_WR, 16'h0000, 1'b1, 8'h00, 9'd511, 11'd1363, 1'b1, 8'hff, 10'd543},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_VRAM_WR, 16'hffff, 1'b0, 8'ha5, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_VRAM_WR, 16'hffff, 1'b1, 8'h5a, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_VRAM_RD, 16'h0000, 1'b0, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'hff, EFF_NONE}},
        '{1'b1, '{OP_VRAM_RD, 16'h8000, 1'b1, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b1, '{OP_VRAM_RD, 16'h7fff, 1'b1, 8'h00, 9'd511, 11'd1363, 1'b1, 8'hff, 10'd543},
            1'b1, '{8'h5a, EFF_NONE}},
        '{1'b1, '{OP_OAM_WR, 16'h0000, 1'b0, 8'h11, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_OAM_WR, 16'hffff, 1'b1, 8'h77, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_OAM_RD, 16'h021f, 1'b0, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h77, EFF_NONE}},
        '{1'b1, '{OP_CG_WR, 16'h0001, 1'b0, 8'hff, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_CG_RD, 16'h0001, 1'b0, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h7f, EFF_NONE}},
        '{1'b1, '{OP_CG_WR, 16'hffff, 1'b0, 8'h80, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b1, '{OP_CG_RD, 16'h01ff, 1'b0, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b1, '{OP_SPARE_A, 16'hffff, 1'b1, 8'hff, 9'd0, 11'd0, 1'b0, 8'hff, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b1, '{OP_SPARE_B, 16'h0000, 1'b0, 8'h00, 9'd0, 11'd6, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b0, '{OP_VRAM_WR, 16'h0002, 1'b0, 8'h33, 9'd0, 11'd6, 1'b0, 8'hc3, 10'd0},
            1'b1, '{8'h00, EFF_MDR}},
        '{1'b0, '{OP_VRAM_WR, 16'h0002, 1'b1, 8'h44, 9'd0, 11'd4, 1'b0, 8'hc3, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b0, '{OP_VRAM_WR, 16'h0003, 1'b0, 8'h99, 9'd0, 11'd5, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b0, '{OP_VRAM_WR, 16'h0003, 1'b0, 8'h99, 9'd225, 11'd4, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b0, '{OP_VRAM_WR, 16'h0003, 1'b0, 8'h99, 9'd225, 11'd5, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_DATA}},
        '{1'b0, '{OP_VRAM_RD, 16'h0002, 1'b0, 8'h00, 9'd261, 11'd1362, 1'b1, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b0, '{OP_VRAM_RD, 16'h0002, 1'b0, 8'h00, 9'd224, 11'd1362, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'hc3, EFF_NONE}},
        '{1'b0, '{OP_VRAM_RD, 16'h0002, 1'b1, 8'h00, 9'd224, 11'd1361, 1'b0, 8'h00, 10'd0},
            1'b1, '{8'h00, EFF_NONE}},
        '{1'b0, '{OP_VRAM_RD, 16'h0003, 1'b0, 8'h00, 9'd262, 11'd1362, 1'b0, 8'h00, 10'd0},
            1'b0, '{8'h00, EFF_NONE}},
        '{1'b0, '{OP_OAM_RD, 16'h0000, 1'b0, 8'h00, 9'd10, 11'd100, 1'b0, 8'h00, 10'd543},
            1'b1, '{8'h77, EFF_NONE}},
        '{1'b0, '{OP_OAM_WR, 16'h021f, 1'b0, 8'h5c, 9'd10, 11'd100, 1'b0, 8'h00, 10'd0},
            1'b0, '{8'h00, EFF_NONE}}
    };

    localparam t_cfg PHASES [N_PHASES] = '{
        '{1'b1, 8'd240, 1'b1, 1'b1, REMAP_8},
        '{1'b0, 8'd225, 1'b0, 1'b0, REMAP_8},
        '{1'b0, 8'd240, 1'b1, 1'b0, REMAP_9},
        '{1'b0, 8'd232, 1'b1, 1'b1, REMAP_10},
        '{1'b1, 8'd225, 1'b0, 1'b1, REMAP_10},
        '{1'b0, 8'd0,   1'b0, 1'b1, REMAP_NONE},
        '{1'b0, 8'd255, 1'b1, 1'b1, REMAP_9},
        '{1'b0, 8'd239, 1'b0, 1'b0, REMAP_NONE}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_wdata;
    logic [OP_W-1:0]       i_opcode;
    logic [ADDR_W-1:0]     i_address;
    logic                  i_byte_half;
    logic [DATA_W-1:0]     i_write_data;
    logic [LINE_W-1:0]     i_line_count;
    logic [DOT_W-1:0]      i_dot_count;
    logic                  i_odd_field;
    logic [DATA_W-1:0]     i_bus_mdr;
    logic [OLATCH_W-1:0]   i_oam_latched_address;
    logic                  o_result_valid;
    logic [DATA_W-1:0]     o_read_data;
    logic [EFF_W-1:0]      o_write_effect;

    // predictor state
    t_cfg              port_cfg;
    logic [15:0]       vram_img [VRAM_WORDS_DEF];
    bit   [1:0]        vram_seen [VRAM_WORDS_DEF];
    int                vram_keys [$];
    logic [DATA_W-1:0] oam_img [OAM_BYTES_DEF];
    bit                oam_seen [OAM_BYTES_DEF];
    int                oam_keys [$];
    logic [DATA_W-1:0] cg_img [PALETTE_BYTES_DEF];
    bit                cg_seen [PALETTE_BYTES_DEF];
    int                cg_keys [$];

    vm_result_t results_due [$];
    logic       row_checked;
    vm_result_t row_result;
    int         mismatches;
    int         cycles;

    video_memory_access_port_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [14:0] vram_word(input logic [15:0] a);
        logic [15:0] x;
        case (port_cfg.vram_remap_mode)
            REMAP_8:  x = (a & 16'hff00) | ((a & 16'h001f) << 3) | ((a >> 5) & 16'h0007);
            REMAP_9:  x = (a & 16'hfe00) | ((a & 16'h003f) << 3) | ((a >> 6) & 16'h0007);
            REMAP_10: x = (a & 16'hfc00) | ((a & 16'h007f) << 3) | ((a >> 7) & 16'h0007);
            default:  x = a;
        endcase
        return x[14:0];
    endfunction

    // cpu address that lands on a given word under the current remap
    function automatic logic [15:0] vram_addr_for(input logic [14:0] w);
        logic [15:0] x;
        x = {1'b0, w};
        case (port_cfg.vram_remap_mode)
            REMAP_8:  return (x & 16'hff00) | ((x >> 3) & 16'h001f) | ((x & 16'h0007) << 5);
            REMAP_9:  return (x & 16'hfe00) | ((x >> 3) & 16'h003f) | ((x & 16'h0007) << 6);
            REMAP_10: return (x & 16'hfc00) | ((x >> 3) & 16'h007f) | ((x & 16'h0007) << 7);
            default:  return x;
        endcase
    endfunction

    function automatic int oam_index(input logic [15:0] a);
        logic [9:0] x;
        x = a[9:0];
        if (x[9]) x = x & OAM_HI_MASK;
        return int'(x) % OAM_BYTES_DEF;
    endfunction

    function automatic logic [15:0] oam_addr_for(input int idx);
        logic [15:0] a;
        a = {6'($urandom), 10'd0};
        if (idx < 'h200) begin
            a[8:0] = 9'(idx);
        end else begin
            a[9]   = 1'b1;
            a[8:5] = 4'($urandom);
            a[4:0] = 5'(idx - 'h200);
        end
        return a;
    endfunction

    // serves one access on the memory images, gives read byte and write effect
    function automatic vm_result_t apply_access(input vm_req_t r);
        vm_result_t res;
        logic [14:0] w;
        logic [7:0]  b;
        int v, h, vd, last, idx;
        bit on, ok;
        res = '{8'h00, EFF_NONE};
        v   = int'(r.line);
        h   = int'(r.dot);
        vd  = int'(port_cfg.visible_lines);
        on  = !port_cfg.display_disable;
        case (r.op)
            OP_VRAM_RD: begin
                w    = vram_word(r.addr);
                last = port_cfg.pal_region ? int'(LAST_LINE_PAL) : int'(LAST_LINE_NTSC);
                if (port_cfg.interlace_on && !r.odd) last++;
                ok = 1'b1;
                if (on) begin
                    if (v == last && h == int'(LINE_END_DOT)) ok = 1'b0;
                    else if (v < vd - 1) ok = 1'b0;
                    else if (v == vd - 1) ok = (h == int'(LINE_END_DOT));
                end
                if (ok) res.rd = r.half ? vram_img[w][15:8] : vram_img[w][7:0];
            end
            OP_VRAM_WR: begin
                w = vram_word(r.addr);
                if (!on) res.eff = EFF_DATA;
                else if (v == 0)
                    res.eff = (h <= int'(WR_EARLY_DOT)) ? EFF_DATA :
                              (h == int'(MDR_DOT)) ? EFF_MDR : EFF_NONE;
                else if (v < vd) res.eff = EFF_NONE;
                else if (v == vd) res.eff = (h > int'(WR_EARLY_DOT)) ? EFF_DATA : EFF_NONE;
                else res.eff = EFF_DATA;
                if (res.eff != EFF_NONE) begin
                    b = (res.eff == EFF_MDR) ? r.mdr : r.wdata;
                    if (r.half) vram_img[w][15:8] = b;
                    else vram_img[w][7:0] = b;
                    if (!vram_seen[w][r.half]) begin
                        vram_seen[w][r.half] = 1'b1;
                        vram_keys.push_back(int'(w) * 2 + int'(r.half));
                    end
                end
            end
            OP_OAM_RD, OP_OAM_WR: begin
                idx = (on && v < vd) ? oam_index({6'd0, r.latched}) : oam_index(r.addr);
                if (r.op == OP_OAM_RD) begin
                    res.rd = oam_img[idx];
                end else begin
                    oam_img[idx] = r.wdata;
                    res.eff = EFF_DATA;
                    if (!oam_seen[idx]) begin
                        oam_seen[idx] = 1'b1;
                        oam_keys.push_back(idx);
                    end
                end
            end
            OP_CG_RD, OP_CG_WR: begin
                idx = int'(r.addr[8:0]);
                if (r.op == OP_CG_RD) begin
                    res.rd = cg_img[idx];
                    if (idx[0]) res.rd = res.rd & CG_ODD_MASK;
                end else begin
                    cg_img[idx] = idx[0] ? (r.wdata & CG_ODD_MASK) : r.wdata;
                    res.eff = EFF_DATA;
                    if (!cg_seen[idx]) begin
                        cg_seen[idx] = 1'b1;
                        cg_keys.push_back(idx);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [LINE_W-1:0] pick_line();
        int vd;
        vd = int'(port_cfg.visible_lines);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LINE_W'(vd - 1);
            2:       return LINE_W'(vd);
            3:       return LINE_W'(vd + 1);
            4:       return LINE_W'(int'(LAST_LINE_NTSC) + int'($urandom_range(0, 1)));
            5:       return LINE_W'(int'(LAST_LINE_PAL) + int'($urandom_range(0, 1)));
            6:       return LINE_W'($urandom_range(0, 8));
            default: return LINE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DOT_W-1:0] pick_dot();
        case ($urandom_range(0, 7))
            0:       return DOT_W'($urandom_range(0, 7));
            1:       return LINE_END_DOT;
            2:       return LINE_END_DOT - 1;
            3:       return LINE_END_DOT + 1;
            default: return DOT_W'($urandom_range(0, 1363));
        endcase
    endfunction

    // reads only ever target bytes that were written before
    function automatic vm_req_t next_access();
        vm_req_t r;
        int pick;
        int key;
        pick      = $urandom_range(0, 99);
        r.op      = OP_VRAM_WR;
        r.addr    = 16'($urandom);
        r.half    = 1'($urandom);
        r.wdata   = 8'($urandom);
        r.line    = pick_line();
        r.dot     = pick_dot();
        r.odd     = 1'($urandom);
        r.mdr     = 8'($urandom);
        r.latched = OLATCH_W'($urandom_range(0, OAM_BYTES_DEF - 1));
        if (pick < 24) begin
            r.op   = OP_VRAM_RD;
            key    = vram_keys[$urandom_range(0, vram_keys.size() - 1)];
            r.half = key[0];
            r.addr = vram_addr_for(15'(key >> 1)) | {1'($urandom), 15'd0};
        end else if (pick < 50) begin
            r.op = OP_VRAM_WR;
        end else if (pick < 62) begin
            r.op      = OP_OAM_RD;
            r.addr    = oam_addr_for(oam_keys[$urandom_range(0, oam_keys.size() - 1)]);
            r.latched = OLATCH_W'(oam_keys[$urandom_range(0, oam_keys.size() - 1)]);
        end else if (pick < 74) begin
            r.op = OP_OAM_WR;
        end else if (pick < 84) begin
            r.op   = OP_CG_RD;
            r.addr = {7'($urandom), 9'(cg_keys[$urandom_range(0, cg_keys.size() - 1)])};
        end else if (pick < 96) begin
            r.op = OP_CG_WR;
        end else begin
            r.op = (pick < 98) ? OP_SPARE_A : OP_SPARE_B;
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string field, input int want, input int got);
        if (mismatches < 10)
            $display("mismatch %s: expected %0h, got %0h at cycle %0d", field, want, got, cycles);
        mismatches++;
    endfunction

    always @(posedge i_clk) begin : result_check
        vm_req_t    seen;
        vm_result_t want;
        vm_result_t pred;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("video_memory_access_port_core: mismatch");
            $finish;
        end else if (!i_rst_n) begin
            port_cfg = '{1'b1, 8'd225, 1'b0, 1'b0, REMAP_NONE};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISPLAY_DISABLE: port_cfg.display_disable = i_cfg_wdata[0];
                    CFG_VISIBLE_LINES:   port_cfg.visible_lines   = i_cfg_wdata;
                    CFG_INTERLACE_ON:    port_cfg.interlace_on    = i_cfg_wdata[0];
                    CFG_PAL_REGION:      port_cfg.pal_region      = i_cfg_wdata[0];
                    CFG_VRAM_REMAP_MODE: port_cfg.vram_remap_mode = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (o_result_valid === 1'b1) begin
                if (results_due.size() == 0) begin
                    note_mismatch("unrequested result", 0, int'(o_read_data));
                end else begin
                    want = results_due.pop_front();
                    if (o_read_data !== want.rd)
                        note_mismatch("read_data", int'(want.rd), int'(o_read_data));
                    if (o_write_effect !== want.eff)
                        note_mismatch("write_effect", int'(want.eff), int'(o_write_effect));
                end
            end
            if (start && busy === 1'b0) begin
                seen = '{i_opcode, i_address, i_byte_half, i_write_data, i_line_count,
                         i_dot_count, i_odd_field, i_bus_mdr, i_oam_latched_address};
                pred = apply_access(seen);
                results_due.push_back(row_checked ? row_result : pred);
            end
        end
    end

    task automatic send_request(input vm_req_t r);
        i_opcode              <= r.op;
        i_address             <= r.addr;
        i_byte_half           <= r.half;
        i_write_data          <= r.wdata;
        i_line_count          <= r.line;
        i_dot_count           <= r.dot;
        i_odd_field           <= r.odd;
        i_bus_mdr             <= r.mdr;
        i_oam_latched_address <= r.latched;
        start                 <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (results_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int burst_left;
        int gap;
        cycles                = 0;
        mismatches            = 0;
        row_checked           = 1'b0;
        row_result            = '0;
        i_rst_n               = 1'b0;
        start                 = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = '0;
        i_cfg_wdata           = '0;
        i_opcode              = '0;
        i_address             = '0;
        i_byte_half           = 1'b0;
        i_write_data          = '0;
        i_line_count          = '0;
        i_dot_count           = '0;
        i_odd_field           = 1'b0;
        i_bus_mdr             = '0;
        i_oam_latched_address = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].blank != port_cfg.display_disable) begin
                start <= 1'b0;
                wait_drained();
                set_register(CFG_DISPLAY_DISABLE, CFG_DAT_W'(DIRECTED[i].blank));
            end
            row_checked = DIRECTED[i].checked;
            row_result  = DIRECTED[i].result;
            send_request(DIRECTED[i].req);
        end
        row_checked = 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            start <= 1'b0;
            wait_drained();
            set_register(CFG_DISPLAY_DISABLE, CFG_DAT_W'(PHASES[p].display_disable));
            set_register(CFG_VISIBLE_LINES,   PHASES[p].visible_lines);
            set_register(CFG_INTERLACE_ON,    CFG_DAT_W'(PHASES[p].interlace_on));
            set_register(CFG_PAL_REGION,      CFG_DAT_W'(PHASES[p].pal_region));
            set_register(CFG_VRAM_REMAP_MODE, CFG_DAT_W'(PHASES[p].vram_remap_mode));
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 19) == 0) begin
                        // hold off until every request has answered
                        start <= 1'b0;
                        wait_drained();
                    end else begin
                        gap = $urandom_range(0, 6);
                        if (gap > 0) begin
                            start <= 1'b0;
                            repeat (gap) @(negedge i_clk);
                        end
                    end
                end
                send_request(next_access());
                burst_left--;
            end
        end

        start <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("video_memory_access_port_core: match");
        end else begin
            $display("video_memory_access_port_core: mismatch");
        end
        $finish;
    end

endmodule

@@ video_memory_access_port_core.f @@
rtl/vmap_pkg.sv
rtl/vmap_ram.sv
rtl/vmap_ctrl.sv
rtl/vmap_datapath.sv
rtl/video_memory_access_port_core.sv
sim/video_memory_access_port_core_tb.sv
